// ----- hw/rtl/lqnt_pkg.sv -----
// ----------------------------------------------------------------------------
// lqnt_pkg
// Shared codes, field widths and controller/datapath interface types for the
// link quality neighbor table.
// ----------------------------------------------------------------------------
package lqnt_pkg;

	localparam int ID_W      = 8;
	localparam int SNR_W     = 8;
	localparam int CNT_W8    = 8;
	localparam int KIND_W    = 2;
	localparam int OUTCOME_W = 3;
	localparam int SLOT_W    = 4;
	localparam int FILL_W    = 5;
	localparam int ENTRY_W   = ID_W + SNR_W + CNT_W8;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	// Result outcomes.
	localparam logic [OUTCOME_W-1:0] OUT_BAD_ID   = 3'd0;
	localparam logic [OUTCOME_W-1:0] OUT_UPDATED  = 3'd1;
	localparam logic [OUTCOME_W-1:0] OUT_ADDED    = 3'd2;
	localparam logic [OUTCOME_W-1:0] OUT_REPLACED = 3'd3;
	localparam logic [OUTCOME_W-1:0] OUT_DROPPED  = 3'd4;
	localparam logic [OUTCOME_W-1:0] OUT_READ     = 3'd5;
	localparam logic [OUTCOME_W-1:0] OUT_CLEARED  = 3'd6;

	// Reserved node ids.
	localparam logic [ID_W-1:0] ID_NONE  = 8'h00;
	localparam logic [ID_W-1:0] ID_BCAST = 8'hFF;

	localparam logic [CNT_W8-1:0] SAMPLES_MAX = 8'd255;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the request fields
		logic scan;      // walk the table, one read per cycle
		logic rd_entry;  // read the entry named by the request index
		logic commit;    // write back, update the fill count, load the result
	} lqnt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic go_scan;   // incoming request is an update with a usable id
		logic go_read;   // incoming request is an entry read
		logic scan_done; // every held entry has been compared
		logic out_free;  // result register can take a new result
	} lqnt_sts_t;

endpackage

// ----- hw/rtl/lqnt_ctrl.sv -----
// ----------------------------------------------------------------------------
// lqnt_ctrl
// Sequencer for the neighbor table: accepts one request, steers the table
// scan or entry read, and commits the result.
// ----------------------------------------------------------------------------
module lqnt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  lqnt_pkg::lqnt_sts_t sts,
	output lqnt_pkg::lqnt_cmd_t cmd
);
	import lqnt_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_RDISS  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.scan     = (state_q == ST_SCAN);
		cmd.rd_entry = (state_q == ST_RDISS);
		cmd.commit   = (state_q == ST_FINISH) && sts.out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (sts.go_scan)
						state_d = ST_SCAN;
					else if (sts.go_read)
						state_d = ST_RDISS;
					else
						state_d = ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done)
					state_d = ST_FINISH;
			end
			ST_RDISS: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ----- hw/rtl/lqnt_dp.sv -----
// ----------------------------------------------------------------------------
// lqnt_dp
// Datapath of the neighbor table: entry memory, fill count, scan for a
// matching id and the weakest entry, averaging and the result register.
// ----------------------------------------------------------------------------
module lqnt_dp #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lqnt_pkg::lqnt_cmd_t                 cmd,
	output lqnt_pkg::lqnt_sts_t                 sts,
	input  logic [lqnt_pkg::KIND_W-1:0]         kind,
	input  logic [lqnt_pkg::ID_W-1:0]           node_id,
	input  logic signed [lqnt_pkg::SNR_W-1:0]   snr,
	input  logic [lqnt_pkg::SLOT_W-1:0]         entry_index,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [lqnt_pkg::OUTCOME_W-1:0]      outcome,
	output logic [lqnt_pkg::SLOT_W-1:0]         slot,
	output logic                                entry_valid,
	output logic [lqnt_pkg::ID_W-1:0]           entry_id,
	output logic signed [lqnt_pkg::SNR_W-1:0]   entry_snr,
	output logic [lqnt_pkg::CNT_W8-1:0]         entry_samples,
	output logic [lqnt_pkg::FILL_W-1:0]         fill_count
);
	import lqnt_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int USE_W = $clog2(TABLE_DEPTH + 1);

	// Entry memory: {id, average snr, sample count}.
	logic [ENTRY_W-1:0] mem_q [TABLE_DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0] wr_data;

	logic [USE_W-1:0]   used_q;
	logic [USE_W-1:0]   used_d;

	// Captured request.
	logic [KIND_W-1:0]       kind_q;
	logic [ID_W-1:0]         id_q;
	logic signed [SNR_W-1:0] snr_q;
	logic [SLOT_W-1:0]       idx_q;

	// Scan state.
	logic [USE_W-1:0]        ptr_q;
	logic                    issue;
	logic                    cmp_vld_s1;
	logic [IDX_W-1:0]        cmp_idx_s1;
	logic                    hit_found_q;
	logic [IDX_W-1:0]        hit_idx_q;
	logic signed [SNR_W-1:0] hit_avg_q;
	logic [CNT_W8-1:0]       hit_cnt_q;
	logic signed [SNR_W-1:0] min_avg_q;
	logic [IDX_W-1:0]        min_idx_q;

	logic [ID_W-1:0]         rd_id;
	logic signed [SNR_W-1:0] rd_avg;
	logic [CNT_W8-1:0]       rd_cnt;

	// Result being formed.
	logic [OUTCOME_W-1:0]    res_outcome;
	logic [SLOT_W-1:0]       res_slot;
	logic                    res_valid;
	logic [ID_W-1:0]         res_id;
	logic [SNR_W-1:0]        res_snr;
	logic [CNT_W8-1:0]       res_cnt;

	logic                    bad_id;
	logic                    table_full;
	logic                    rd_in_range;
	logic [9:0]              avg_sum;
	logic [9:0]              avg_adj;
	logic [SNR_W-1:0]        new_avg;
	logic [CNT_W8-1:0]       new_cnt;
	logic                    rsp_valid_q;

	assign rd_id  = rd_data_q[ENTRY_W-1 -: ID_W];
	assign rd_avg = $signed(rd_data_q[CNT_W8 +: SNR_W]);
	assign rd_cnt = rd_data_q[CNT_W8-1:0];

	assign bad_id      = (id_q == ID_NONE) || (id_q == ID_BCAST);
	assign table_full  = (32'(used_q) >= TABLE_DEPTH);
	assign rd_in_range = (32'(idx_q) < 32'(used_q));

	assign issue   = cmd.scan && (ptr_q < used_q);
	assign rd_en   = issue || cmd.rd_entry;
	assign rd_addr = cmd.rd_entry ? IDX_W'(idx_q) : ptr_q[IDX_W-1:0];

	always_comb begin
		sts           = '0;
		sts.go_scan   = (kind == KIND_UPDATE) && (node_id != ID_NONE) &&
		                (node_id != ID_BCAST);
		sts.go_read   = (kind == KIND_READ);
		sts.scan_done = (ptr_q == used_q) && !cmp_vld_s1;
		sts.out_free  = !rsp_valid_q || !rsp_stall;
	end

	// Running average (snr + 3*avg) / 4, quotient truncated toward zero.
	always_comb begin
		avg_sum = {{2{snr_q[SNR_W-1]}}, snr_q} +
		          {hit_avg_q[SNR_W-1], hit_avg_q, 1'b0} +
		          {{2{hit_avg_q[SNR_W-1]}}, hit_avg_q};
		avg_adj = avg_sum + (avg_sum[9] ? 10'd3 : 10'd0);
		new_avg = avg_adj[9:2];
		new_cnt = (hit_cnt_q == SAMPLES_MAX) ? hit_cnt_q : hit_cnt_q + 8'd1;
	end

	always_comb begin
		res_outcome = OUT_BAD_ID;
		res_slot    = '0;
		res_valid   = 1'b0;
		res_id      = '0;
		res_snr     = '0;
		res_cnt     = '0;
		wr_en       = 1'b0;
		wr_addr     = '0;
		used_d      = used_q;
		case (kind_q)
			KIND_UPDATE: begin
				if (bad_id) begin
					res_outcome = OUT_BAD_ID;
				end else if (hit_found_q) begin
					res_outcome = OUT_UPDATED;
					wr_en       = 1'b1;
					wr_addr     = hit_idx_q;
					res_snr     = new_avg;
					res_cnt     = new_cnt;
				end else if (!table_full) begin
					res_outcome = OUT_ADDED;
					wr_en       = 1'b1;
					wr_addr     = used_q[IDX_W-1:0];
					res_snr     = snr_q;
					res_cnt     = 8'd1;
					used_d      = used_q + 1'b1;
				end else if (snr_q > min_avg_q) begin
					res_outcome = OUT_REPLACED;
					wr_en       = 1'b1;
					wr_addr     = min_idx_q;
					res_snr     = snr_q;
					res_cnt     = 8'd1;
				end else begin
					res_outcome = OUT_DROPPED;
				end
				if (wr_en) begin
					res_slot  = SLOT_W'(wr_addr);
					res_valid = 1'b1;
					res_id    = id_q;
				end
			end
			KIND_READ: begin
				res_outcome = OUT_READ;
				if (rd_in_range) begin
					res_valid = 1'b1;
					res_id    = rd_id;
					res_snr   = rd_avg;
					res_cnt   = rd_cnt;
				end
			end
			KIND_CLEAR: begin
				res_outcome = OUT_CLEARED;
				used_d      = '0;
			end
			default: begin
				res_outcome = OUT_BAD_ID;
			end
		endcase
		wr_en = wr_en && cmd.commit;
	end

	assign wr_data = {res_id, res_snr, res_cnt};

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			id_q   <= node_id;
			snr_q  <= snr;
			idx_q  <= entry_index;
		end
	end

	// Scan: reads issue one per cycle, and each compare follows in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			cmp_vld_s1  <= 1'b0;
			hit_found_q <= 1'b0;
		end else if (cmd.load) begin
			ptr_q       <= '0;
			cmp_vld_s1  <= 1'b0;
			hit_found_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= issue;
			if (issue)
				ptr_q <= ptr_q + 1'b1;
			if (cmp_vld_s1 && !hit_found_q && (rd_id == id_q))
				hit_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue)
			cmp_idx_s1 <= ptr_q[IDX_W-1:0];
		if (cmp_vld_s1) begin
			if (!hit_found_q && (rd_id == id_q)) begin
				hit_idx_q <= cmp_idx_s1;
				hit_avg_q <= rd_avg;
				hit_cnt_q <= rd_cnt;
			end
			if ((cmp_idx_s1 == '0) || (rd_avg < min_avg_q)) begin
				min_avg_q <= rd_avg;
				min_idx_q <= cmp_idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				used_q      <= used_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			outcome       <= res_outcome;
			slot          <= res_slot;
			entry_valid   <= res_valid;
			entry_id      <= res_id;
			entry_snr     <= res_snr;
			entry_samples <= res_cnt;
			fill_count    <= FILL_W'(used_d);
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ----- hw/rtl/link_quality_neighbor_table.sv -----
// ----------------------------------------------------------------------------
// link_quality_neighbor_table
// Table of heard radio nodes with a running average SNR and sample count per
// node, supporting sample updates, reads by slot and clearing.
// ----------------------------------------------------------------------------
// The block takes one request at a time on the req channel and answers each
// with exactly one transfer on the rsp channel. An update (kind 0) with a
// usable id walks the held entries through the single read port of the entry
// memory, one entry per cycle, looking for the id and for the weakest entry.
// An update with a reserved id, a clear or an unused kind goes from
// acceptance straight to the commit of its result, while a read by slot
// first reads the addressed entry through the same memory read port and
// then commits. The result sits in an output register, so
// the next request is accepted while an earlier result still waits for the
// consumer; a new result is only held back when that register is still full.
// A known id has its average folded as (snr + 3*avg) / 4 rounded toward zero
// and its sample count saturates at 255. An unknown id is appended while the
// table has room; on a full table it replaces the weakest entry (lowest
// average, first slot on ties) only if its snr is strictly greater. Entries
// are not cleared by reset or by a clear request: only the fill count is,
// and slots at or above the fill count are never reported.
// ----------------------------------------------------------------------------
module link_quality_neighbor_table #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [lqnt_pkg::KIND_W-1:0]         kind,
	input  logic [lqnt_pkg::ID_W-1:0]           node_id,
	input  logic signed [lqnt_pkg::SNR_W-1:0]   snr,
	input  logic [lqnt_pkg::SLOT_W-1:0]         entry_index,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [lqnt_pkg::OUTCOME_W-1:0]      outcome,
	output logic [lqnt_pkg::SLOT_W-1:0]         slot,
	output logic                                entry_valid,
	output logic [lqnt_pkg::ID_W-1:0]           entry_id,
	output logic signed [lqnt_pkg::SNR_W-1:0]   entry_snr,
	output logic [lqnt_pkg::CNT_W8-1:0]         entry_samples,
	output logic [lqnt_pkg::FILL_W-1:0]         fill_count
);
	import lqnt_pkg::*;

	lqnt_cmd_t cmd;
	lqnt_sts_t sts;

	// The controller owns sequencing; the datapath owns all storage.
	lqnt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lqnt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.kind          (kind),
		.node_id       (node_id),
		.snr           (snr),
		.entry_index   (entry_index),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.outcome       (outcome),
		.slot          (slot),
		.entry_valid   (entry_valid),
		.entry_id      (entry_id),
		.entry_snr     (entry_snr),
		.entry_samples (entry_samples),
		.fill_count    (fill_count)
	);

	// Once a request is taken, the block is busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted on two consecutive cycles");

	// A freshly added or replacing entry always starts with one sample.
	a_new_entry_one_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (outcome == OUT_ADDED || outcome == OUT_REPLACED))
		|-> (entry_valid && entry_samples == 8'd1 && entry_snr == entry_snr))
		else $error("new entry reported without a single sample");

	// Results that touch no entry report no entry.
	a_no_entry_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (outcome == OUT_DROPPED || outcome == OUT_CLEARED ||
		outcome == OUT_BAD_ID))
		|-> (!entry_valid && slot == '0 && entry_id == '0 && entry_samples == '0))
		else $error("entry fields set on a result that touches no entry");

endmodule

// ----- test/link_quality_neighbor_table_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// link_quality_neighbor_table_tb
// Self-checking testbench for the link quality neighbor table.
// A short directed table covers reserved ids, the unused kind, extreme SNR
// values, averaging with truncation toward zero, a full table with a tie on
// the weakest entry, replacement, dropping and clearing. Random traffic
// follows, including a long run on one node that drives its sample count
// into saturation. Every response is checked field by field against a
// cycle-free shadow of the table, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module link_quality_neighbor_table_tb;

	import lqnt_pkg::*;

	localparam int DEPTH       = 16;
	localparam int QUIET_LIMIT = 2000;
	localparam int CALM_ITEMS  = 150;
	localparam int DRAIN_WAIT  = 40;

	// The package names the three defined kinds; the fourth encoding is
	// reserved and must be answered as a no-op.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// One request as it crosses the req channel.
	typedef struct {
		logic [KIND_W-1:0]       kind;
		logic [ID_W-1:0]         id;
		logic signed [SNR_W-1:0] snr;
		logic [SLOT_W-1:0]       idx;
	} nbr_req_t;

	// One response as it crosses the rsp channel.
	typedef struct {
		logic [OUTCOME_W-1:0]    outcome;
		logic [SLOT_W-1:0]       slot;
		logic                    valid;
		logic [ID_W-1:0]         id;
		logic signed [SNR_W-1:0] snr;
		logic [CNT_W8-1:0]       samples;
		logic [FILL_W-1:0]       fill;
	} nbr_result_t;

	// A stimulus row: the request, and for rows whose answer is obvious the
	// typed-in response that must come back.
	typedef struct {
		nbr_req_t    req;
		bit          typed;
		nbr_result_t res;
	} stim_row_t;

	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    req_valid   = 1'b0;
	logic                    req_stall;
	logic [KIND_W-1:0]       kind        = KIND_READ;
	logic [ID_W-1:0]         node_id     = '0;
	logic signed [SNR_W-1:0] snr         = '0;
	logic [SLOT_W-1:0]       entry_index = '0;
	logic                    rsp_valid;
	logic                    rsp_stall   = 1'b0;
	logic [OUTCOME_W-1:0]    outcome;
	logic [SLOT_W-1:0]       slot;
	logic                    entry_valid;
	logic [ID_W-1:0]         entry_id;
	logic signed [SNR_W-1:0] entry_snr;
	logic [CNT_W8-1:0]       entry_samples;
	logic [FILL_W-1:0]       fill_count;

	// Shadow copy of the neighbor table, advanced once per accepted request.
	logic [ID_W-1:0]         shadow_id  [DEPTH];
	logic signed [SNR_W-1:0] shadow_avg [DEPTH];
	logic [CNT_W8-1:0]       shadow_cnt [DEPTH];
	int                      shadow_fill = 0;

	stim_row_t   stim_list [$];
	nbr_result_t pending_results [$];
	int          mismatches  = 0;
	int          quiet_cycles = 0;
	int          stall_left  = 0;
	logic        calm        = 1'b0;

	link_quality_neighbor_table #(
		.TABLE_DEPTH(DEPTH)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.kind         (kind),
		.node_id      (node_id),
		.snr          (snr),
		.entry_index  (entry_index),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.outcome      (outcome),
		.slot         (slot),
		.entry_valid  (entry_valid),
		.entry_id     (entry_id),
		.entry_snr    (entry_snr),
		.entry_samples(entry_samples),
		.fill_count   (fill_count)
	);

	always #6 clk = ~clk;

	function automatic nbr_result_t mk_res(logic [OUTCOME_W-1:0] oc, logic [SLOT_W-1:0] sl,
			logic vl, logic [ID_W-1:0] id, logic signed [SNR_W-1:0] sn,
			logic [CNT_W8-1:0] sm, logic [FILL_W-1:0] fl);
		nbr_result_t r;
		r.outcome = oc;
		r.slot    = sl;
		r.valid   = vl;
		r.id      = id;
		r.snr     = sn;
		r.samples = sm;
		r.fill    = fl;
		return r;
	endfunction

	// Row whose response comes from the shadow table.
	function automatic void row(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
			logic signed [SNR_W-1:0] sn, logic [SLOT_W-1:0] ix);
		stim_row_t s;
		s.req.kind = k;
		s.req.id   = id;
		s.req.snr  = sn;
		s.req.idx  = ix;
		s.typed    = 1'b0;
		s.res      = mk_res(OUT_BAD_ID, '0, 1'b0, '0, '0, '0, '0);
		stim_list.push_back(s);
	endfunction

	// Row with the response typed in by hand.
	function automatic void row_exp(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
			logic signed [SNR_W-1:0] sn, logic [SLOT_W-1:0] ix, nbr_result_t r);
		row(k, id, sn, ix);
		stim_list[$].typed = 1'b1;
		stim_list[$].res   = r;
	endfunction

	// Random request. Most updates draw from a pool of 24 ids, which is
	// larger than the table, so hits, appends, replacements and drops all
	// occur. Clears are rare enough that the table regularly fills up.
	function automatic nbr_req_t random_req();
		nbr_req_t r;
		int pick;
		pick   = $urandom_range(0, 99);
		r.kind = KIND_UPDATE;
		r.id   = 8'($urandom_range(1, 24));
		r.snr  = 8'($urandom_range(0, 255));
		r.idx  = 4'($urandom_range(0, 15));
		if (pick < 15) begin
			r.id = 8'($urandom_range(0, 255));
		end else if (pick < 60) begin
			r.id = r.id;
		end else if (pick < 86) begin
			r.kind = KIND_READ;
			r.id   = 8'($urandom_range(0, 255));
		end else if (pick < 87) begin
			r.kind = KIND_CLEAR;
		end else if (pick < 93) begin
			r.kind = KIND_UNUSED;
			r.id   = 8'($urandom_range(0, 255));
		end else begin
			r.id = pick[0] ? ID_NONE : ID_BCAST;
		end
		return r;
	endfunction

	// Applies one request to the shadow table and returns the response the
	// block must give for it.
	function automatic nbr_result_t predict_neighbor_result(nbr_req_t r);
		nbr_result_t o;
		int hit;
		int weakest;
		int avg;
		o       = mk_res(OUT_BAD_ID, '0, 1'b0, '0, '0, '0, '0);
		hit     = -1;
		weakest = 0;
		case (r.kind)
			KIND_UPDATE: begin
				if (r.id != ID_NONE && r.id != ID_BCAST) begin
					for (int i = 0; i < shadow_fill; i++)
						if (hit < 0 && shadow_id[i] == r.id)
							hit = i;
					if (hit >= 0) begin
						// SystemVerilog integer division truncates toward zero.
						avg = (int'(r.snr) + 3 * int'(shadow_avg[hit])) / 4;
						shadow_avg[hit] = avg[7:0];
						if (shadow_cnt[hit] != SAMPLES_MAX)
							shadow_cnt[hit] = shadow_cnt[hit] + 8'd1;
						o.outcome = OUT_UPDATED;
					end else begin
						if (shadow_fill < DEPTH) begin
							hit = shadow_fill;
							shadow_fill++;
							o.outcome = OUT_ADDED;
						end else begin
							// Weakest is the lowest average; strict compare keeps
							// the first slot on ties.
							for (int i = 1; i < DEPTH; i++)
								if (shadow_avg[i] < shadow_avg[weakest])
									weakest = i;
							if (r.snr > shadow_avg[weakest]) begin
								hit = weakest;
								o.outcome = OUT_REPLACED;
							end else begin
								o.outcome = OUT_DROPPED;
							end
						end
						if (hit >= 0) begin
							shadow_id[hit]  = r.id;
							shadow_avg[hit] = r.snr;
							shadow_cnt[hit] = 8'd1;
						end
					end
					if (hit >= 0) begin
						o.slot    = 4'(hit);
						o.valid   = 1'b1;
						o.id      = shadow_id[hit];
						o.snr     = shadow_avg[hit];
						o.samples = shadow_cnt[hit];
					end
				end
			end
			KIND_READ: begin
				o.outcome = OUT_READ;
				if (r.idx < shadow_fill) begin
					o.valid   = 1'b1;
					o.id      = shadow_id[r.idx];
					o.snr     = shadow_avg[r.idx];
					o.samples = shadow_cnt[r.idx];
				end
			end
			KIND_CLEAR: begin
				shadow_fill = 0;
				o.outcome   = OUT_CLEARED;
			end
			default: begin
				o.outcome = OUT_BAD_ID;
			end
		endcase
		o.fill = 5'(shadow_fill);
		return o;
	endfunction

	function automatic void check_field(string name, logic signed [31:0] want,
			logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Build the stimulus list: the directed table first, then random
	// traffic around a long single-node run.
	initial begin : build_stimulus
		int s;
		// Fresh table: a read finds nothing, reserved ids and the unused
		// kind change nothing.
		row_exp(KIND_READ, 8'h00, 8'sd0, 4'd0,
			mk_res(OUT_READ, 4'd0, 1'b0, 8'd0, 8'sd0, 8'd0, 5'd0));
		row_exp(KIND_UPDATE, ID_NONE, 8'sd5, 4'd0,
			mk_res(OUT_BAD_ID, 4'd0, 1'b0, 8'd0, 8'sd0, 8'd0, 5'd0));
		row_exp(KIND_UPDATE, ID_BCAST, -8'sd7, 4'd0,
			mk_res(OUT_BAD_ID, 4'd0, 1'b0, 8'd0, 8'sd0, 8'd0, 5'd0));
		row_exp(KIND_UNUSED, 8'h33, 8'sd9, 4'hF,
			mk_res(OUT_BAD_ID, 4'd0, 1'b0, 8'd0, 8'sd0, 8'd0, 5'd0));
		// Extreme SNR values, then folding in the opposite extreme and a
		// negative fold that must truncate toward zero.
		row_exp(KIND_UPDATE, 8'd1, 8'sd127, 4'd0,
			mk_res(OUT_ADDED, 4'd0, 1'b1, 8'd1, 8'sd127, 8'd1, 5'd1));
		row(KIND_UPDATE, 8'd1, 8'sh80, 4'd0);
		row_exp(KIND_UPDATE, 8'd2, 8'sh80, 4'd0,
			mk_res(OUT_ADDED, 4'd1, 1'b1, 8'd2, 8'sh80, 8'd1, 5'd2));
		row(KIND_UPDATE, 8'd2, -8'sd1, 4'd0);
		// Fill the table; ids 5 and 11 tie for the weakest average.
		for (int id = 3; id <= DEPTH; id++) begin
			s = (id == 5 || id == 11) ? -120 : 10 * id - 60;
			row(KIND_UPDATE, 8'(id), 8'(s), 4'd0);
		end
		row_exp(KIND_READ, 8'd0, 8'sd0, 4'd15,
			mk_res(OUT_READ, 4'd0, 1'b1, 8'd16, 8'sd100, 8'd1, 5'd16));
		// Full table: the tie goes to the lower slot, an equal snr is not
		// enough to replace, a stronger one is.
		row_exp(KIND_UPDATE, 8'd200, -8'sd119, 4'd0,
			mk_res(OUT_REPLACED, 4'd4, 1'b1, 8'd200, -8'sd119, 8'd1, 5'd16));
		row_exp(KIND_UPDATE, 8'd201, -8'sd120, 4'd0,
			mk_res(OUT_DROPPED, 4'd0, 1'b0, 8'd0, 8'sd0, 8'd0, 5'd16));
		row(KIND_UPDATE, 8'd201, -8'sd119, 4'd0);
		// Clearing forgets every entry even though the memory keeps them.
		row_exp(KIND_CLEAR, 8'd0, 8'sd0, 4'd0,
			mk_res(OUT_CLEARED, 4'd0, 1'b0, 8'd0, 8'sd0, 8'd0, 5'd0));
		row_exp(KIND_READ, 8'd0, 8'sd0, 4'd0,
			mk_res(OUT_READ, 4'd0, 1'b0, 8'd0, 8'sd0, 8'd0, 5'd0));
		row_exp(KIND_UPDATE, 8'd16, -8'sd5, 4'd0,
			mk_res(OUT_ADDED, 4'd0, 1'b1, 8'd16, -8'sd5, 8'd1, 5'd1));

		for (int n = 0; n < 400; n++)
			stim_list.push_back('{random_req(), 1'b0,
				mk_res(OUT_BAD_ID, '0, 1'b0, '0, '0, '0, '0)});
		// One node heard 260 times in a row saturates its sample count.
		row(KIND_CLEAR, 8'd0, 8'sd0, 4'd0);
		for (int n = 0; n < 260; n++)
			row(KIND_UPDATE, 8'h5A, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
		row(KIND_READ, 8'd0, 8'sd0, 4'd0);
		for (int n = 0; n < 400; n++)
			stim_list.push_back('{random_req(), 1'b0,
				mk_res(OUT_BAD_ID, '0, 1'b0, '0, '0, '0, '0)});
	end

	// Request side. Some rows get a random idle burst in front of them;
	// valid stays high across back-to-back transfers. At the accepting
	// edge the shadow table is advanced and the expected response queued.
	initial begin : drive_requests
		nbr_result_t p;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int n = 0; n < stim_list.size(); n++) begin
			if (n == stim_list.size() - CALM_ITEMS)
				calm <= 1'b1;
			if (n < stim_list.size() - CALM_ITEMS && $urandom_range(0, 5) == 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			req_valid   <= 1'b1;
			kind        <= stim_list[n].req.kind;
			node_id     <= stim_list[n].req.id;
			snr         <= stim_list[n].req.snr;
			entry_index <= stim_list[n].req.idx;
			@(posedge clk);
			while (req_stall)
				@(posedge clk);
			p = predict_neighbor_result(stim_list[n].req);
			if (stim_list[n].typed)
				pending_results.push_back(stim_list[n].res);
			else
				pending_results.push_back(p);
		end
		req_valid <= 1'b0;

		// Drain: wait for every queued response, then give the block time
		// to show any stray extra transfer.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Response side back-pressure: random stall bursts, none in the closing
	// stretch of the run.
	always @(posedge clk) begin
		if (calm)
			stall_left = 0;
		else if (stall_left > 0)
			stall_left--;
		else if ($urandom_range(0, 9) == 0)
			stall_left = $urandom_range(1, 16);
		rsp_stall <= (stall_left > 0);
	end

	// Every response transfer is matched with the oldest expectation.
	always @(posedge clk) begin : check_responses
		nbr_result_t e;
		if (arst_n && rsp_valid === 1'b1 && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$error("response transfer with nothing pending, outcome %0d", outcome);
				mismatches++;
			end else begin
				e = pending_results.pop_front();
				check_field("outcome", e.outcome, outcome);
				check_field("slot", e.slot, slot);
				check_field("entry_valid", e.valid, entry_valid);
				check_field("entry_id", e.id, entry_id);
				check_field("entry_snr", e.snr, entry_snr);
				check_field("entry_samples", e.samples, entry_samples);
				check_field("fill_count", e.fill, fill_count);
			end
		end
	end

	// Watchdog: a long stretch without any transfer on either channel means
	// the block has hung.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

// ----- link_quality_neighbor_table.f -----
hw/rtl/lqnt_pkg.sv
hw/rtl/lqnt_ctrl.sv
hw/rtl/lqnt_dp.sv
hw/rtl/link_quality_neighbor_table.sv
test/link_quality_neighbor_table_tb.sv
